// ----- design/assert_macros.svh -----
// Assertion macros shared by the span fill RTL.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bsf_pkg.sv -----
// Shared constants, field widths and controller/datapath interface types
// for the span fill block. Depends on nothing.
package bsf_pkg;

   localparam int SCREEN_BYTES  = 1024;
   localparam int MAX_ROW_BYTES = 64;
   localparam int PIX_PER_BYTE  = 8;

   localparam int ADDR_W  = (SCREEN_BYTES > 1) ? $clog2(SCREEN_BYTES) : 1;
   localparam int DATA_W  = PIX_PER_BYTE;
   localparam int BIT_W   = $clog2(PIX_PER_BYTE);
   localparam int X_W     = 9;
   localparam int ROW_W   = 10;
   localparam int BADDR_W = 10;
   localparam int RB_W    = 7;
   localparam int COL_W   = X_W - BIT_W;
   localparam int PROD_W  = ROW_W + RB_W;
   localparam int WID_W   = RB_W + BIT_W;

   localparam logic [RB_W-1:0] ROW_BYTES_RESET = RB_W'(4);

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic load;
      logic check;
      logic rd_issue;
      logic eval;
      logic step;
      logic result_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic cmd_read;
      logic draw_ok;
      logic span_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ----- design/bsf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/bsf_dp.sv -----
// Datapath of the span fill block: row_bytes register, item registers, range
// checks, byte walker with read-modify-write, frame store and result register.
// Depends on bsf_pkg, bsf_ram and assert_macros.svh.
`include "assert_macros.svh"

module bsf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bsf_pkg::ctrl_cmd_type         cmd,
   output bsf_pkg::dp_stat_type          stat,
   input  logic                          req_cmd,
   input  logic [bsf_pkg::X_W-1:0]       req_x_start,
   input  logic [bsf_pkg::X_W-1:0]       req_x_end,
   input  logic [bsf_pkg::ROW_W-1:0]     req_row,
   input  logic [bsf_pkg::BADDR_W-1:0]   req_byte_address,
   input  logic                          csr_we,
   input  logic [bsf_pkg::RB_W-1:0]      csr_row_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bsf_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                          rsp_status
);
   import bsf_pkg::*;

   logic [RB_W-1:0]    rb_ff;
   logic               cmd_ff;
   logic [X_W-1:0]     xs_ff;
   logic [X_W-1:0]     xe_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [BADDR_W-1:0] addr_ff;
   logic [PROD_W-1:0]  base_ff;
   logic               rb_ok_ff;
   logic               order_ok_ff;
   logic               width_ok_ff;
   logic               draw_ok_ff;
   logic [COL_W-1:0]   col_ff;
   logic               wr_pend_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic [DATA_W-1:0]  wr_mask_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_status_ff;

   logic [PROD_W-1:0]  span_addr;
   logic [PROD_W:0]    fit_sum;
   logic               fit;
   logic               draw_ok;
   logic               addr_bad;
   logic [COL_W-1:0]   first_col;
   logic [COL_W-1:0]   last_col;
   logic [DATA_W-1:0]  lmask;
   logic [DATA_W-1:0]  rmask;
   logic [DATA_W-1:0]  wr_mask_in;
   logic               out_free;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [DATA_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [DATA_W-1:0]  ram_rdata;

   assign first_col = xs_ff[X_W-1:BIT_W];
   assign last_col  = xe_ff[X_W-1:BIT_W];
   assign span_addr = base_ff + PROD_W'(col_ff);

   // The whole row must fit: base + row_bytes may equal the store size.
   assign fit_sum  = (PROD_W+1)'(base_ff) + (PROD_W+1)'(rb_ff);
   assign fit      = fit_sum <= (PROD_W+1)'(SCREEN_BYTES);
   assign draw_ok  = rb_ok_ff && order_ok_ff && width_ok_ff && fit;
   assign addr_bad = int'(addr_ff) >= SCREEN_BYTES;

   assign lmask = {DATA_W{1'b1}} >> xs_ff[BIT_W-1:0];
   assign rmask = {DATA_W{1'b1}} << (BIT_W'(PIX_PER_BYTE - 1) - xe_ff[BIT_W-1:0]);

   always_comb begin
      wr_mask_in = {DATA_W{1'b1}};
      if (col_ff == first_col) begin
         wr_mask_in = wr_mask_in & lmask;
      end
      if (col_ff == last_col) begin
         wr_mask_in = wr_mask_in & rmask;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The write port serves the clearing pass, or otherwise the write half of
   // the read-modify-write issued in the previous cycle.
   assign ram_we    = cmd.clr_step || wr_pend_ff;
   assign ram_waddr = cmd.clr_step ? clr_ff : wr_addr_ff;
   assign ram_wdata = cmd.clr_step ? '0 : (ram_rdata | wr_mask_ff);
   assign ram_re    = cmd.step || cmd.rd_issue;
   assign ram_raddr = cmd.step ? ADDR_W'(span_addr) : ADDR_W'(addr_ff);

   bsf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SCREEN_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff        <= ROW_BYTES_RESET;
         clr_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            rb_ff <= csr_row_bytes;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         wr_pend_ff <= cmd.step;
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         xs_ff   <= req_x_start;
         xe_ff   <= req_x_end;
         row_ff  <= req_row;
         addr_ff <= req_byte_address;
      end
      if (cmd.check) begin
         base_ff     <= PROD_W'(row_ff) * PROD_W'(rb_ff);
         rb_ok_ff    <= (rb_ff != '0) && (int'(rb_ff) <= MAX_ROW_BYTES);
         order_ok_ff <= xs_ff <= xe_ff;
         width_ok_ff <= WID_W'(xe_ff) < {rb_ff, {BIT_W{1'b0}}};
      end
      if (cmd.eval) begin
         draw_ok_ff <= draw_ok;
         col_ff     <= first_col;
      end else if (cmd.step) begin
         col_ff <= col_ff + COL_W'(1);
      end
      if (cmd.step) begin
         wr_addr_ff <= ADDR_W'(span_addr);
         wr_mask_ff <= wr_mask_in;
      end
      if (cmd.result_load) begin
         if (cmd_ff == CMD_READ) begin
            rsp_data_ff   <= addr_bad ? '0 : ram_rdata;
            rsp_status_ff <= addr_bad;
         end else begin
            rsp_data_ff   <= '0;
            rsp_status_ff <= !draw_ok_ff;
         end
      end
   end

   assign stat.clr_last  = clr_ff == ADDR_W'(SCREEN_BYTES - 1);
   assign stat.cmd_read  = cmd_ff == CMD_READ;
   assign stat.draw_ok   = draw_ok;
   assign stat.span_last = col_ff == last_col;
   assign stat.out_free  = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   `ASSERT_IMPL(a_wr_follows_rd, clock, reset, wr_pend_ff, $past(cmd.step), "write without read")
   `ASSERT_IMPL(a_clr_no_rmw, clock, reset, cmd.clr_step, !wr_pend_ff, "clear collides with write")
   `ASSERT_IMPL(a_span_in_store, clock, reset, cmd.step, span_addr < PROD_W'(SCREEN_BYTES), "span byte outside store")

endmodule

// ----- design/bsf_ctrl.sv -----
// Controller of the span fill block: clearing pass, item sequencing,
// byte walk and result hand-off. Depends on bsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bsf_pkg::dp_stat_type  stat,
   output bsf_pkg::ctrl_cmd_type cmd
);
   import bsf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_EVAL,
      ST_SPAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      req_stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check    = 1'b1;
            cmd.rd_issue = stat.cmd_read;
            state_in     = stat.cmd_read ? ST_RESULT : ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.draw_ok ? ST_SPAN : ST_RESULT;
         end
         ST_SPAN: begin
            cmd.step = 1'b1;
            if (stat.span_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last byte's write completes in this cycle.
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_stall_in = state_in != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

   `ASSERT_NEXT(a_accept_to_check, clock, reset, req_valid && !req_stall_ff, state_ff == ST_CHECK, "accepted beat not checked")
   `ASSERT_IMPL(a_load_when_free, clock, reset, cmd.result_load, stat.out_free, "result register overrun")

endmodule

// ----- design/bitmap_span_fill.sv -----
// Span fill on a one-bit-per-pixel frame store. A read beat goes through the check and
// result states; a draw goes through check, evaluation, the walk over its bytes, drain
// and result (evaluation straight to result when rejected), one store read-modify-write
// per byte through the single write port. No new beat is taken until the result is loaded.
// Synchronous active-high reset sets row_bytes to 4 and starts a clearing pass over every
// byte of the frame store, during which no beat is accepted.
module bitmap_span_fill (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [bsf_pkg::X_W-1:0]       req_x_start,
   input  logic [bsf_pkg::X_W-1:0]       req_x_end,
   input  logic [bsf_pkg::ROW_W-1:0]     req_row,
   input  logic [bsf_pkg::BADDR_W-1:0]   req_byte_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bsf_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                          rsp_status,
   input  logic                          csr_we,
   input  logic [bsf_pkg::RB_W-1:0]      csr_row_bytes
);
   import bsf_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   bsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_row          (req_row),
      .req_byte_address (req_byte_address),
      .csr_we           (csr_we),
      .csr_row_bytes    (csr_row_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status)
   );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for bitmap_span_fill: predicts every response beat from a
// shadow frame store and compares it field by field under random handshake pressure.
// Depends on bsf_pkg and the bitmap_span_fill RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsf_pkg::*;

   localparam int  CLK_HALF    = 6;
   localparam int  CYCLE_LIMIT = 800_000;
   localparam int  TAIL_CYCLES = 80;
   localparam int  REPORT_MAX  = 10;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              status;
   } span_result_type;

   // Shadow frame store plus the queue of responses it predicts.
   class span_fill_board;
      logic [DATA_W-1:0] pixels [SCREEN_BYTES];
      int unsigned       row_bytes;
      span_result_type   expected_rsp [$];
      int                failures;
      int                reads, draws_ok, draws_rejected;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         row_bytes = ROW_BYTES_RESET;
         failures = 0;
         reads = 0;
         draws_ok = 0;
         draws_rejected = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function bit span_fits(int unsigned xs, int unsigned xe, int unsigned row);
         if (row_bytes == 0 || row_bytes > MAX_ROW_BYTES) return 0;
         if (xs > xe) return 0;
         if (xe >= row_bytes * PIX_PER_BYTE) return 0;
         if ((row + 1) * row_bytes > SCREEN_BYTES) return 0;
         return 1;
      endfunction

      function void note_beat(logic cmd, logic [X_W-1:0] xs, logic [X_W-1:0] xe,
                              logic [ROW_W-1:0] row, logic [BADDR_W-1:0] addr);
         span_result_type   r;
         int unsigned       base, first_byte, last_byte;
         logic [DATA_W-1:0] lmask, rmask;
         r.data = '0;
         r.status = 1'b0;
         if (cmd == CMD_READ) begin
            reads++;
            if (int'(addr) >= SCREEN_BYTES) r.status = 1'b1;
            else r.data = pixels[addr];
         end else if (!span_fits(xs, xe, row)) begin
            draws_rejected++;
            r.status = 1'b1;
         end else begin
            draws_ok++;
            base = row * row_bytes;
            first_byte = xs / PIX_PER_BYTE;
            last_byte = xe / PIX_PER_BYTE;
            lmask = 8'hFF >> xs[2:0];
            rmask = 8'(8'hFF << (7 - int'(xe[2:0])));
            if (first_byte == last_byte) begin
               pixels[base + first_byte] |= lmask & rmask;
            end else begin
               pixels[base + first_byte] |= lmask;
               for (int j = first_byte + 1; j < last_byte; j++) pixels[base + j] = 8'hFF;
               pixels[base + last_byte] |= rmask;
            end
         end
         expected_rsp.push_back(r);
      endfunction

      function void check_result(logic [DATA_W-1:0] data, logic status);
         span_result_type want;
         if (expected_rsp.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("[%0t] unexpected response beat: data=%02h status=%0d",
                        $realtime, data, status);
            return;
         end
         want = expected_rsp.pop_front();
         if (data !== want.data || status !== want.status) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display({"[%0t] response mismatch: expected data=%02h status=%0d,",
                         " got data=%02h status=%0d"},
                        $realtime, want.data, want.status, data, status);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cmd = CMD_DRAW;
   logic [X_W-1:0]       req_x_start = '0;
   logic [X_W-1:0]       req_x_end = '0;
   logic [ROW_W-1:0]     req_row = '0;
   logic [BADDR_W-1:0]   req_byte_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DATA_W-1:0]    rsp_read_data;
   logic                 rsp_status;
   logic                 csr_we = 1'b0;
   logic [RB_W-1:0]      csr_row_bytes = ROW_BYTES_RESET;

   span_fill_board board = new();
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int settings_written = 0;
   int last_base = 0;

   bitmap_span_fill u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_row          (req_row),
      .req_byte_address (req_byte_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_row_bytes    (csr_row_bytes)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycles, board.pending());
         $display("bitmap_span_fill: mismatch");
         $finish;
      end
   end

   // Both channels are observed at the rising edge only.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            board.note_beat(req_cmd, req_x_start, req_x_end, req_row, req_byte_address);
         if (rsp_valid === 1'b1 && !rsp_stall)
            board.check_result(rsp_read_data, rsp_status);
      end
   end

   // The receiver switches between free running, light, heavy and long-run stalls.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 2) == 0);
         2: rsp_stall = ($urandom_range(0, 3) != 0);
         default: rsp_stall = ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
      endcase
   end

   task automatic send_beat(logic cmd, int unsigned xs, int unsigned xe,
                            int unsigned row, int unsigned addr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_cmd = cmd;
      req_x_start = X_W'(xs);
      req_x_end = X_W'(xe);
      req_row = ROW_W'(row);
      req_byte_address = BADDR_W'(addr);
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // The block is idle once every response has come back, so the write is safe here.
   task automatic write_row_bytes(int unsigned value);
      drain();
      csr_we = 1'b1;
      csr_row_bytes = RB_W'(value);
      board.row_bytes = value;
      settings_written++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_beat();
      int unsigned rb, width, rows_ok, xs, xe, row, addr, pick;
      bit          rb_ok;
      rb = board.row_bytes;
      rb_ok = (rb >= 1 && rb <= MAX_ROW_BYTES);
      width = rb_ok ? rb * PIX_PER_BYTE : 32;
      rows_ok = rb_ok ? SCREEN_BYTES / rb : 16;
      xs = $urandom_range(0, 511);
      xe = $urandom_range(0, 511);
      row = $urandom_range(0, 1023);
      addr = $urandom_range(0, 1023);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // Reads lean toward the row drawn most recently so filled bytes come back.
         if ($urandom_range(0, 1) == 0) begin
            addr = last_base + $urandom_range(0, rb_ok ? rb - 1 : 3);
            if (addr > 1023) addr = 1023;
         end
         send_beat(CMD_READ, xs, xe, row, addr);
         return;
      end
      if (pick < 80) begin
         row = $urandom_range(0, rows_ok - 1);
         xs = $urandom_range(0, width - 1);
         if ($urandom_range(0, 3) == 0) xe = $urandom_range(xs, width - 1);
         else xe = (xs + $urandom_range(0, 15) < width) ? xs + $urandom_range(0, 15) : width - 1;
         if (xe < xs) xe = xs;
         last_base = row * rb;
      end else if (pick < 90) begin
         case ($urandom_range(0, 2))
            0: if (width > 1) begin
               xe = $urandom_range(0, width - 2);
               xs = $urandom_range(xe + 1, width - 1);
               row = $urandom_range(0, rows_ok - 1);
            end
            1: if (width < 512) begin
               xs = $urandom_range(0, width - 1);
               xe = $urandom_range(width, 511);
               row = $urandom_range(0, rows_ok - 1);
            end
            default: if (rows_ok < 1024) begin
               xs = $urandom_range(0, width - 1);
               xe = $urandom_range(xs, width - 1);
               row = $urandom_range(rows_ok, 1023);
            end
         endcase
      end
      send_beat(CMD_DRAW, xs, xe, row, addr);
   endtask

   initial begin
      int plan [12];
      int rb, count;
      plan = '{1, 64, 0, 127, -1, 65, -1, 4, -1, 64, -1, 1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats at the reset width of four bytes per row, then at 64 and at 1.
      send_beat(CMD_READ, 0, 0, 0, 0);
      send_beat(CMD_DRAW, 0, 0, 0, 0);
      send_beat(CMD_DRAW, 3, 5, 0, 1023);
      send_beat(CMD_DRAW, 0, 31, 1, 0);
      send_beat(CMD_DRAW, 5, 26, 2, 0);
      send_beat(CMD_DRAW, 7, 8, 3, 0);
      send_beat(CMD_DRAW, 10, 9, 4, 0);
      send_beat(CMD_DRAW, 0, 32, 4, 0);
      send_beat(CMD_DRAW, 511, 511, 0, 0);
      send_beat(CMD_DRAW, 0, 31, 255, 0);
      send_beat(CMD_DRAW, 0, 31, 256, 0);
      send_beat(CMD_DRAW, 0, 0, 1023, 0);
      send_beat(CMD_READ, 511, 511, 1023, 0);
      send_beat(CMD_READ, 0, 0, 0, 4);
      send_beat(CMD_READ, 0, 0, 0, 8);
      send_beat(CMD_READ, 0, 0, 0, 9);
      send_beat(CMD_READ, 0, 0, 0, 12);
      send_beat(CMD_READ, 0, 0, 0, 13);
      send_beat(CMD_READ, 0, 0, 0, 1020);
      write_row_bytes(64);
      send_beat(CMD_DRAW, 0, 511, 15, 0);
      send_beat(CMD_DRAW, 0, 511, 16, 0);
      send_beat(CMD_READ, 0, 0, 0, 1023);
      write_row_bytes(1);
      send_beat(CMD_DRAW, 0, 7, 1023, 0);
      send_beat(CMD_READ, 0, 0, 0, 1023);

      foreach (plan[p]) begin
         rb = (plan[p] < 0) ? $urandom_range(1, MAX_ROW_BYTES) : plan[p];
         write_row_bytes(rb);
         last_base = 0;
         count = (rb >= 1 && rb <= MAX_ROW_BYTES) ? 115 : 40;
         repeat (count) random_beat();
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.pending() != 0) begin
         $display("%0d responses never arrived", board.pending());
         board.failures += board.pending();
      end
      $display("covered %0d reads, %0d accepted draws and %0d rejected draws",
               board.reads, board.draws_ok, board.draws_rejected);
      $display("across %0d row width settings in %0d cycles, %0d failures",
               settings_written, cycles, board.failures);
      if (board.failures == 0) begin
         $display("bitmap_span_fill: match");
      end else begin
         $display("bitmap_span_fill: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/bsf_pkg.sv
design/bsf_ram.sv
design/bsf_dp.sv
design/bsf_ctrl.sv
design/bitmap_span_fill.sv
verif/tb.sv
